### design/occfr_pkg.sv
// Shared constants, types and slot codes of the occupancy frontier cell detector.
`timescale 1ns / 1ps
`default_nettype none
package occfr_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int CX_W        = $clog2(MAX_WIDTH);
	localparam int WIDTH_W     = CX_W + 1;
	localparam int CY_W        = 16;
	localparam int GW_W        = 11;
	localparam int GH_W        = 16;
	localparam int MARK_W      = 2;
	localparam int WIN_W       = 9 * MARK_W;
	localparam int SLOTS       = 4;
	localparam int SLOT_W      = $clog2(SLOTS);
	localparam int QUEUE_DEPTH = 4;

	localparam logic signed [7:0] OCC_LIMIT = 8'sd100;

	// Result slots of one run, in raster order
	localparam logic [SLOT_W-1:0] SLOT_PREV_ROW_PREV_COL = 2'd0;
	localparam logic [SLOT_W-1:0] SLOT_PREV_ROW_THIS_COL = 2'd1;
	localparam logic [SLOT_W-1:0] SLOT_THIS_ROW_PREV_COL = 2'd2;
	localparam logic [SLOT_W-1:0] SLOT_THIS_ROW_THIS_COL = 2'd3;

	typedef struct packed {
		logic [WIDTH_W-1:0] width;
		logic [CY_W-1:0]    height;
		logic               restart;
	} cfg_t;

	typedef struct packed {
		logic [SLOTS-1:0] live;
		logic [SLOTS-1:0] frontier;
		logic [CX_W-1:0]  cx;
		logic [CY_W-1:0]  cy;
	} run_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage
`default_nettype wire

### design/occfr_if.sv
// Cell and verdict stream interfaces of the occupancy frontier cell detector.
`timescale 1ns / 1ps
`default_nettype none
interface occfr_cell_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] cell_value;

	modport source (output valid, output cell_value, input ready);
	modport sink (input valid, input cell_value, output ready);
endinterface

interface occfr_result_if;
	import occfr_pkg::*;
	logic            valid;
	logic            ready;
	logic [CX_W-1:0] cell_x;
	logic [CY_W-1:0] cell_y;
	logic            is_frontier;
	logic            last_in_run;
	logic            grid_done;

	modport source (output valid, output cell_x, output cell_y, output is_frontier,
		output last_in_run, output grid_done, input ready);
	modport sink (input valid, input cell_x, input cell_y, input is_frontier,
		input last_in_run, input grid_done, output ready);
endinterface
`default_nettype wire

### design/occupancy_frontier_cell_detect_unit.sv
// Top level of the occupancy frontier cell detector: register port and part wiring.
`timescale 1ns / 1ps
`default_nettype none
// Occupancy cells stream in raster order on the cell channel, one beat per clock unless the
// queue is full, and each cell's frontier verdict (free and touching an unknown in-bounds
// 8-neighbour) leaves on the verdict channel as soon as its last neighbour has arrived. The
// block takes one cell every cycle unless stalled; a cell normally frees one verdict, the
// first cell of a row none, the last cell of a row two and the last cell of the grid four, so
// the verdict side also averages one beat per clock and the end-of-row bursts are absorbed
// by a four-run queue between the front part (line store, 3x3 window, verdict logic) and
// the back part (one beat per cycle unless stalled). A verdict passes the line store
// read, window and verdict stage, queue and output stage. Two rows of marks sit in a line
// store with one read/write port per row bank; it needs no clearing after reset.
// Registers: grid_width at byte address 0 (0 acts as 1, above 1024 acts as 1024) and
// grid_height at byte address 4 (0 acts as 1). Any write restarts the grid at cell (0, 0);
// write them only while no verdict is outstanding. After the last cell of the grid the
// position wraps and a new grid begins.
module occupancy_frontier_cell_detect_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	occfr_cell_if.sink     cells,
	occfr_result_if.source verdict
);
	import occfr_pkg::*;

	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	localparam logic [GW_W-1:0] GRID_WIDTH_RESET  = 11'd1024;
	localparam logic [GH_W-1:0] GRID_HEIGHT_RESET = 16'd1024;

	logic [GW_W-1:0] grid_width_q;
	logic [GH_W-1:0] grid_height_q;
	logic            cfg_write;
	cfg_t            cfg;
	logic            push;
	run_t            push_run;
	logic            pop;
	run_t            pop_run;
	q_status_t       q_status;

	// Register port: no wait states, register picked by address bit 2
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_WIDTH_RESET;
			grid_height_q <= GRID_HEIGHT_RESET;
		end else if (cfg_write) begin
			case (paddr[2])
				REG_GRID_WIDTH:  grid_width_q  <= pwdata[GW_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= pwdata[GH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_GRID_WIDTH:  prdata = 32'(grid_width_q);
			REG_GRID_HEIGHT: prdata = 32'(grid_height_q);
			default:         prdata = '0;
		endcase
	end

	// Clamp the registers to the sizes the datapath handles
	always_comb begin
		if (grid_width_q == '0) begin
			cfg.width = WIDTH_W'(1);
		end else if (32'(grid_width_q) > MAX_WIDTH) begin
			cfg.width = WIDTH_W'(MAX_WIDTH);
		end else begin
			cfg.width = WIDTH_W'(grid_width_q);
		end
		cfg.height  = (grid_height_q == '0) ? CY_W'(1) : CY_W'(grid_height_q);
		cfg.restart = cfg_write;
	end

	occfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cells    (cells),
		.q_status (q_status),
		.push     (push),
		.push_run (push_run)
	);

	occfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_run (push_run),
		.pop      (pop),
		.pop_run  (pop_run),
		.q_status (q_status)
	);

	occfr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_run  (pop_run),
		.q_status (q_status),
		.pop      (pop),
		.verdict  (verdict)
	);

endmodule
`default_nettype wire

### design/occfr_front.sv
// Front part: cell intake, raster counters, line store, 3x3 mark window and verdicts.
`timescale 1ns / 1ps
`default_nettype none
module occfr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  occfr_pkg::cfg_t    cfg,
	occfr_cell_if.sink         cells,
	input  occfr_pkg::q_status_t q_status,
	output logic               push,
	output occfr_pkg::run_t    push_run
);
	import occfr_pkg::*;

	// Window column 0 is the oldest; row 0 is two rows up. Bit 0 free, bit 1 unknown.
	function automatic logic judge(input logic [WIN_W-1:0] win, input int col, input int row,
		input logic lv, input logic rv, input logic tv, input logic bv);
		logic hit;
		logic en;
		int   dc;
		int   dr;
		hit = 1'b0;
		for (dc = -1; dc <= 1; dc++) begin
			for (dr = -1; dr <= 1; dr++) begin
				en = !(dc == 0 && dr == 0) && (dc >= 0 || lv) && (dc <= 0 || rv)
					&& (dr >= 0 || tv) && (dr <= 0 || bv)
					&& (col + dc >= 0) && (col + dc <= 2) && (row + dr >= 0) && (row + dr <= 2);
				if (en) begin
					hit = hit | win[((col + dc) * 3 + (row + dr)) * MARK_W + 1];
				end
			end
		end
		return win[(col * 3 + row) * MARK_W] & hit;
	endfunction

	logic [CX_W-1:0]   cx_q;
	logic [CY_W-1:0]   cy_q;
	logic [WIN_W-1:0]  win_q;
	logic [MARK_W-1:0] bank0 [MAX_WIDTH];
	logic [MARK_W-1:0] bank1 [MAX_WIDTH];

	logic              valid_s1;
	logic [MARK_W-1:0] mark_s1;
	logic [MARK_W-1:0] rd0_s1;
	logic [MARK_W-1:0] rd1_s1;
	logic [CX_W-1:0]   cx_s1;
	logic [CY_W-1:0]   cy_s1;
	logic              last_col_s1;
	logic              last_row_s1;

	logic              accept;
	logic [MARK_W-1:0] mark;
	logic              last_col;
	logic              last_row;
	logic [MARK_W-1:0] top;
	logic [MARK_W-1:0] mid;
	logic [WIN_W-1:0]  win_new;
	logic              col_ge1;
	logic              col_ge2;
	logic              row_ge1;
	logic              row_ge2;
	logic [SLOTS-1:0]  live;
	logic [SLOTS-1:0]  frontier;
	logic              go_s1;

	assign accept   = cells.valid && cells.ready;
	assign mark     = {(cells.cell_value < 8'sd0) || (cells.cell_value > OCC_LIMIT),
		cells.cell_value == 8'sd0};
	assign last_col = {1'b0, cx_q} == (cfg.width - WIDTH_W'(1));
	assign last_row = cy_q == (cfg.height - CY_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
		end else if (cfg.restart) begin
			cx_q <= '0;
			cy_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				cx_q <= '0;
				cy_q <= last_row ? '0 : cy_q + CY_W'(1);
			end else begin
				cx_q <= cx_q + CX_W'(1);
			end
		end
	end

	// Read both row banks and overwrite the oldest row with the new mark
	always_ff @(posedge clk) begin
		if (accept) begin
			rd0_s1 <= bank0[cx_q];
			rd1_s1 <= bank1[cx_q];
			if (!cy_q[0]) begin
				bank0[cx_q] <= mark;
			end else begin
				bank1[cx_q] <= mark;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mark_s1     <= mark;
			cx_s1       <= cx_q;
			cy_s1       <= cy_q;
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
		end
	end

	assign top     = cy_s1[0] ? rd1_s1 : rd0_s1;
	assign mid     = cy_s1[0] ? rd0_s1 : rd1_s1;
	assign win_new = {mark_s1, mid, top, win_q[WIN_W-1:3*MARK_W]};

	assign col_ge1 = cx_s1 != '0;
	assign col_ge2 = cx_s1 > CX_W'(1);
	assign row_ge1 = cy_s1 != '0;
	assign row_ge2 = cy_s1 > CY_W'(1);

	assign live[SLOT_PREV_ROW_PREV_COL] = row_ge1 && col_ge1;
	assign live[SLOT_PREV_ROW_THIS_COL] = row_ge1 && last_col_s1;
	assign live[SLOT_THIS_ROW_PREV_COL] = last_row_s1 && col_ge1;
	assign live[SLOT_THIS_ROW_THIS_COL] = last_row_s1 && last_col_s1;

	assign frontier[SLOT_PREV_ROW_PREV_COL] = judge(win_new, 1, 1, col_ge2, 1'b1, row_ge2, 1'b1);
	assign frontier[SLOT_PREV_ROW_THIS_COL] = judge(win_new, 2, 1, col_ge1, 1'b0, row_ge2, 1'b1);
	assign frontier[SLOT_THIS_ROW_PREV_COL] = judge(win_new, 1, 2, col_ge2, 1'b1, row_ge1, 1'b0);
	assign frontier[SLOT_THIS_ROW_THIS_COL] = judge(win_new, 2, 2, col_ge1, 1'b0, row_ge1, 1'b0);

	// A cell that frees nothing never waits on the queue
	assign go_s1       = valid_s1 && (!(|live) || !q_status.full);
	assign push        = valid_s1 && (|live) && !q_status.full;
	assign cells.ready = !valid_s1 || go_s1;
	assign push_run    = '{live: live, frontier: frontier, cx: cx_s1, cy: cy_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			win_q    <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (go_s1) begin
				valid_s1 <= 1'b0;
			end
			if (cfg.restart) begin
				win_q <= '0;
			end else if (go_s1) begin
				win_q <= win_new;
			end
		end
	end

endmodule
`default_nettype wire

### design/occfr_queue.sv
// Short run queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module occfr_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  occfr_pkg::run_t      push_run,
	input  logic                 pop,
	output occfr_pkg::run_t      pop_run,
	output occfr_pkg::q_status_t q_status
);
	import occfr_pkg::*;

	localparam int QP_W = $clog2(QUEUE_DEPTH);

	run_t            entries_q [QUEUE_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QP_W:0]   count_q;

	assign q_status.full  = count_q == (QP_W+1)'(QUEUE_DEPTH);
	assign q_status.empty = count_q == '0;
	assign pop_run        = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + QP_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + QP_W'(1);
			end
			count_q <= count_q + (QP_W+1)'(push) - (QP_W+1)'(pop);
		end
	end

endmodule
`default_nettype wire

### design/occfr_back.sv
// Back part: unpacks each run into verdict beats, one per cycle while the verdict channel is ready.
`timescale 1ns / 1ps
`default_nettype none
module occfr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  occfr_pkg::run_t      pop_run,
	input  occfr_pkg::q_status_t q_status,
	output logic                 pop,
	occfr_result_if.source       verdict
);
	import occfr_pkg::*;

	logic              run_valid_q;
	logic [SLOTS-1:0]  mask_q;
	logic [SLOTS-1:0]  frontier_q;
	logic [CX_W-1:0]   cx_q;
	logic [CY_W-1:0]   cy_q;

	logic [SLOT_W-1:0] slot;
	logic [SLOTS-1:0]  rest;
	logic              last;
	logic              accept_out;

	always_comb begin
		if (mask_q[SLOT_PREV_ROW_PREV_COL]) begin
			slot = SLOT_PREV_ROW_PREV_COL;
		end else if (mask_q[SLOT_PREV_ROW_THIS_COL]) begin
			slot = SLOT_PREV_ROW_THIS_COL;
		end else if (mask_q[SLOT_THIS_ROW_PREV_COL]) begin
			slot = SLOT_THIS_ROW_PREV_COL;
		end else begin
			slot = SLOT_THIS_ROW_THIS_COL;
		end
	end

	assign rest       = mask_q & ~(SLOTS'(1) << slot);
	assign last       = rest == '0;
	assign accept_out = verdict.valid && verdict.ready;
	assign pop        = !q_status.empty && (!run_valid_q || (accept_out && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
			mask_q      <= '0;
		end else if (pop) begin
			run_valid_q <= 1'b1;
			mask_q      <= pop_run.live;
		end else if (accept_out) begin
			mask_q <= rest;
			if (last) begin
				run_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			frontier_q <= pop_run.frontier;
			cx_q       <= pop_run.cx;
			cy_q       <= pop_run.cy;
		end
	end

	// Slot bit 0 picks the column, bit 1 the row
	assign verdict.valid       = run_valid_q;
	assign verdict.cell_x      = slot[0] ? cx_q : cx_q - CX_W'(1);
	assign verdict.cell_y      = slot[1] ? cy_q : cy_q - CY_W'(1);
	assign verdict.is_frontier = frontier_q[slot];
	assign verdict.last_in_run = last;
	assign verdict.grid_done   = slot == SLOT_THIS_ROW_THIS_COL;

	a_valid_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid_q |-> mask_q != '0)
		else $error("verdict shown with no slot left in the run");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.valid && verdict.grid_done |-> verdict.last_in_run)
		else $error("grid end beat is not the last of its run");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("run taken from an empty queue");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		accept_out && !last |=> run_valid_q && mask_q == $past(rest))
		else $error("run dropped before its last beat");

endmodule
`default_nettype wire
